/* sv/clex_pkg.sv */
package clex_pkg;

  localparam int POS_W         = 16;
  localparam int MAX_TOKEN_LEN = 64;
  localparam int CNT_W         = $clog2(MAX_TOKEN_LEN + 2);
  localparam int KEYWORD_COUNT = 32;
  localparam int KW_BYTES      = 8;
  localparam int QDEPTH        = 4;
  localparam int QCNT_W        = $clog2(QDEPTH + 1);

  // token kinds
  localparam logic [5:0] KIND_IDENT  = 6'd0;
  localparam logic [5:0] KIND_PLUS   = 6'd33;
  localparam logic [5:0] KIND_MINUS  = 6'd34;
  localparam logic [5:0] KIND_STAR   = 6'd35;
  localparam logic [5:0] KIND_SLASH  = 6'd36;
  localparam logic [5:0] KIND_COMMA  = 6'd37;
  localparam logic [5:0] KIND_SEMI   = 6'd38;
  localparam logic [5:0] KIND_ASSIGN = 6'd39;
  localparam logic [5:0] KIND_LPAREN = 6'd40;
  localparam logic [5:0] KIND_RPAREN = 6'd41;
  localparam logic [5:0] KIND_LBRACE = 6'd42;
  localparam logic [5:0] KIND_RBRACE = 6'd43;
  localparam logic [5:0] KIND_DEC    = 6'd44;
  localparam logic [5:0] KIND_FLOAT  = 6'd45;
  localparam logic [5:0] KIND_ERROR  = 6'd46;

  // error causes
  localparam logic [2:0] CAUSE_NONE       = 3'd0;
  localparam logic [2:0] CAUSE_BAD_CHAR   = 3'd1;
  localparam logic [2:0] CAUSE_ZERO       = 3'd2;
  localparam logic [2:0] CAUSE_LETTER     = 3'd3;
  localparam logic [2:0] CAUSE_TWO_POINTS = 3'd4;
  localparam logic [2:0] CAUSE_TRAIL_PT   = 3'd5;
  localparam logic [2:0] CAUSE_TOO_LONG   = 3'd6;

  // scanner modes
  localparam logic [2:0] M_IDLE   = 3'd0;
  localparam logic [2:0] M_WORD   = 3'd1;
  localparam logic [2:0] M_MINUS  = 3'd2;
  localparam logic [2:0] M_ZERO   = 3'd3;
  localparam logic [2:0] M_NUM    = 3'd4;
  localparam logic [2:0] M_POINT  = 3'd5;
  localparam logic [2:0] M_ZPOINT = 3'd6;
  localparam logic [2:0] M_SKIP   = 3'd7;

  // characters
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;

  // keyword text, first character in the most significant used byte
  localparam logic [63:0] KW_TEXT [32] = '{
    "void", "char", "short", "int", "long", "float", "double", "auto",
    "static", "const", "signed", "unsigned", "extern", "volatile", "register",
    "return", "goto", "if", "else", "switch", "case", "default", "break",
    "for", "while", "do", "continue", "typedef", "struct", "enum", "union",
    "sizeof"
  };
  localparam logic [3:0] KW_LEN [32] = '{
    4'd4, 4'd4, 4'd5, 4'd3, 4'd4, 4'd5, 4'd6, 4'd4,
    4'd6, 4'd5, 4'd6, 4'd8, 4'd6, 4'd8, 4'd8, 4'd6,
    4'd4, 4'd2, 4'd4, 4'd6, 4'd4, 4'd7, 4'd5, 4'd3,
    4'd5, 4'd2, 4'd8, 4'd7, 4'd6, 4'd4, 4'd5, 4'd6
  };

  typedef struct packed {
    logic [5:0]       kind;
    logic             neg;
    logic [POS_W-1:0] start;
    logic [CNT_W-1:0] len;
    logic [2:0]       cause;
    logic             last;
  } tok_t;

  typedef struct packed {
    logic [1:0] n;
    tok_t       t0;
    tok_t       t1;
  } push_t;

  function automatic tok_t mk_tok(input logic [5:0] kind, input logic neg,
                                  input logic [POS_W-1:0] start,
                                  input logic [CNT_W-1:0] len, input logic [2:0] cause);
    tok_t t;
    t.kind  = kind;
    t.neg   = neg;
    t.start = start;
    t.len   = len;
    t.cause = cause;
    t.last  = 1'b0;
    return t;
  endfunction

  // parallel keyword match; identifier when nothing hits
  function automatic logic [5:0] kw_kind(input logic [63:0] w, input logic [CNT_W-1:0] cnt);
    logic [5:0] k;
    logic       hit;
    k = KIND_IDENT;
    for (int i = KEYWORD_COUNT - 1; i >= 0; i--) begin
      hit = (cnt == CNT_W'(KW_LEN[i]));
      for (int j = 0; j < KW_BYTES; j++) begin
        if (j < int'(KW_LEN[i])) begin
          if (w[8*j +: 8] != KW_TEXT[i][8*(int'(KW_LEN[i]) - 1 - j) +: 8]) hit = 1'b0;
        end
      end
      if (hit) k = 6'(i + 1);
    end
    return k;
  endfunction

  // single-character operators other than minus; KIND_IDENT when none
  function automatic logic [5:0] op_kind(input logic [7:0] c);
    logic [5:0] k;
    unique case (c)
      CH_PLUS:   k = KIND_PLUS;
      CH_STAR:   k = KIND_STAR;
      CH_SLASH:  k = KIND_SLASH;
      CH_COMMA:  k = KIND_COMMA;
      CH_SEMI:   k = KIND_SEMI;
      CH_EQUAL:  k = KIND_ASSIGN;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      default:   k = KIND_IDENT;
    endcase
    return k;
  endfunction

endpackage

/* sv/c_subset_lexer_top.sv */
// Streaming lexer for a small subset of C.
// Input channel: one source byte per transaction in in_tdata, in_tlast on the
// final byte of a text. Output channel: one token per transaction; out_tuser
// carries the token kind, out_tdata the sign flag, start offset, length and
// error cause, and out_tlast marks the last token caused by one input byte.
// An accepted byte is held in the input register and scanned from there
// once the output queue has room; its tokens are written into the queue,
// from which the output presents them. Bytes are taken at one per cycle
// while each byte yields at most one token and the receiver takes every
// token; a byte that yields two tokens needs two output transactions. The
// output queue holds up to four tokens and the scanner stops once three or
// more wait, so a stalled receiver backs the input up after a few
// transactions and nothing is dropped. Whitespace and bytes skipped after
// an error give no token. Reset empties the queue and returns the scanner
// to the start of a text with offsets counting from zero; in_tlast returns
// the scanner there too once its byte's tokens have been produced.
module c_subset_lexer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_byte
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // negative_literal, start_offset, token_length, error_cause
  output logic [5:0]  out_tuser,  // token_kind
  output logic        out_tlast   // run_end
);
  import clex_pkg::*;

  push_t push;
  logic  room;
  tok_t  head;

  clex_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_eot   (in_tlast),
    .room     (room),
    .push     (push)
  );

  clex_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_tok   (head)
  );

  assign out_tdata = {5'd0, head.cause, head.len, head.start, head.neg};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

/* sv/clex_core.sv */
module clex_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_eot,
  input  logic            room,
  output clex_pkg::push_t push
);
  import clex_pkg::*;

  logic             in_v_r, in_v_nxt;
  logic [7:0]       byte_r;
  logic             eot_r;
  logic             fire;

  logic [2:0]       mode_r, mode_nxt;
  logic [63:0]      word_r, word_nxt;
  logic [POS_W-1:0] start_r, start_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             minus_r, minus_nxt;
  logic             point_r, point_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;

  logic             is_alpha, is_digit, is_space, is_under, is_dot, is_zero, is_minus;
  logic [5:0]       op_k;
  logic             op_v;
  logic             at_max;
  logic [CNT_W-1:0] cnt_inc;

  logic [2:0]       st_mode;
  logic             st_tok_v;
  tok_t             st_tok;
  tok_t             fin_tok;

  logic [2:0]       m_mode;
  logic [63:0]      m_word;
  logic [POS_W-1:0] m_start;
  logic [CNT_W-1:0] m_cnt;
  logic             m_minus, m_point;
  logic             do_fin, do_start, fail_v;
  logic [2:0]       fail_cause;
  logic [CNT_W-1:0] fail_len;

  logic             a0_v, a1_v, b_v;
  tok_t             a0, a1, b_tok;

  function automatic tok_t finish_tok(input logic [2:0] mode, input logic [63:0] w,
                                      input logic [POS_W-1:0] start,
                                      input logic [CNT_W-1:0] cnt,
                                      input logic minus, input logic point);
    tok_t t;
    unique case (mode)
      M_WORD:  t = mk_tok(kw_kind(w, cnt), 1'b0, start, cnt, CAUSE_NONE);
      M_MINUS: t = mk_tok(KIND_MINUS, 1'b0, start, CNT_W'(1), CAUSE_NONE);
      default: t = mk_tok(point ? KIND_FLOAT : KIND_DEC, minus, start, cnt, CAUSE_NONE);
    endcase
    return t;
  endfunction

  // input register
  assign fire     = in_v_r & room;
  assign in_ready = ~in_v_r | fire;
  assign in_v_nxt = (in_valid & in_ready) | (in_v_r & ~fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
      eot_r  <= in_eot;
    end
  end

  // character classes
  assign is_alpha = ((byte_r >= CH_LO_A) && (byte_r <= CH_LO_Z)) ||
                    ((byte_r >= CH_UP_A) && (byte_r <= CH_UP_Z));
  assign is_digit = (byte_r >= CH_ZERO) && (byte_r <= CH_NINE);
  assign is_space = (byte_r == CH_SPACE) || (byte_r == CH_TAB) ||
                    (byte_r == CH_CR) || (byte_r == CH_LF);
  assign is_under = (byte_r == CH_UNDER);
  assign is_dot   = (byte_r == CH_POINT);
  assign is_zero  = (byte_r == CH_ZERO);
  assign is_minus = (byte_r == CH_MINUS);
  assign op_k     = op_kind(byte_r);
  assign op_v     = (op_k != KIND_IDENT);

  assign at_max  = (cnt_r >= CNT_W'(MAX_TOKEN_LEN));
  assign cnt_inc = CNT_W'(cnt_r + 1'b1);

  // outcome of a byte that opens a token
  always_comb begin
    if (is_space) begin
      st_mode = M_IDLE;
    end else if (is_alpha || is_under) begin
      st_mode = M_WORD;
    end else if (is_zero) begin
      st_mode = M_ZERO;
    end else if (is_digit) begin
      st_mode = M_NUM;
    end else if (is_minus) begin
      st_mode = M_MINUS;
    end else if (op_v) begin
      st_mode = M_IDLE;
    end else begin
      st_mode = M_SKIP;
    end
    st_tok_v = ~is_space & ~is_alpha & ~is_under & ~is_digit & ~is_minus;
    st_tok   = op_v ? mk_tok(op_k, 1'b0, pos_r, CNT_W'(1), CAUSE_NONE)
                    : mk_tok(KIND_ERROR, 1'b0, pos_r, CNT_W'(1), CAUSE_BAD_CHAR);
  end

  assign fin_tok = finish_tok(mode_r, word_r, start_r, cnt_r, minus_r, point_r);

  // byte step
  always_comb begin
    m_mode     = mode_r;
    m_word     = word_r;
    m_start    = start_r;
    m_cnt      = cnt_r;
    m_minus    = minus_r;
    m_point    = point_r;
    do_fin     = 1'b0;
    do_start   = 1'b0;
    fail_v     = 1'b0;
    fail_cause = CAUSE_NONE;
    fail_len   = cnt_inc;
    unique case (mode_r)
      M_IDLE: begin
        do_start = 1'b1;
      end
      M_WORD: begin
        if (is_alpha || is_digit || is_under) begin
          if (at_max) begin
            fail_v     = 1'b1;
            fail_cause = CAUSE_TOO_LONG;
            fail_len   = cnt_r;
          end else begin
            m_cnt = cnt_inc;
            if (cnt_r < CNT_W'(KW_BYTES)) m_word[{cnt_r[2:0], 3'b000} +: 8] = byte_r;
          end
        end else begin
          do_fin   = 1'b1;
          do_start = 1'b1;
        end
      end
      M_MINUS: begin
        if (is_digit) begin
          m_mode  = is_zero ? M_ZERO : M_NUM;
          m_minus = 1'b1;
          m_cnt   = CNT_W'(2);
        end else begin
          do_fin   = 1'b1;
          do_start = 1'b1;
        end
      end
      M_ZERO: begin
        if (is_dot) begin
          if (at_max) begin
            fail_v     = 1'b1;
            fail_cause = CAUSE_TOO_LONG;
            fail_len   = cnt_r;
          end else begin
            m_cnt   = cnt_inc;
            m_mode  = M_ZPOINT;
            m_point = 1'b1;
          end
        end else begin
          fail_v     = 1'b1;
          fail_cause = CAUSE_ZERO;
        end
      end
      M_NUM, M_POINT: begin
        if (is_digit) begin
          if (at_max) begin
            fail_v     = 1'b1;
            fail_cause = CAUSE_TOO_LONG;
            fail_len   = cnt_r;
          end else begin
            m_cnt  = cnt_inc;
            m_mode = M_NUM;
          end
        end else if (is_dot) begin
          if (point_r) begin
            fail_v     = 1'b1;
            fail_cause = CAUSE_TWO_POINTS;
          end else if (at_max) begin
            fail_v     = 1'b1;
            fail_cause = CAUSE_TOO_LONG;
            fail_len   = cnt_r;
          end else begin
            m_cnt   = cnt_inc;
            m_mode  = M_POINT;
            m_point = 1'b1;
          end
        end else if (is_alpha) begin
          fail_v     = 1'b1;
          fail_cause = CAUSE_LETTER;
        end else begin
          do_fin   = 1'b1;
          do_start = 1'b1;
        end
      end
      M_ZPOINT: begin
        if (is_digit) begin
          if (at_max) begin
            fail_v     = 1'b1;
            fail_cause = CAUSE_TOO_LONG;
            fail_len   = cnt_r;
          end else begin
            m_cnt  = cnt_inc;
            m_mode = M_NUM;
          end
        end else begin
          fail_v     = 1'b1;
          fail_cause = CAUSE_TRAIL_PT;
        end
      end
      default: begin
      end
    endcase
    if (fail_v) m_mode = M_SKIP;
    if (do_start) begin
      m_mode  = st_mode;
      m_minus = 1'b0;
      m_point = 1'b0;
      m_start = pos_r;
      m_cnt   = is_space ? CNT_W'(0) : CNT_W'(1);
      m_word  = (is_alpha || is_under) ? {56'd0, byte_r} : 64'd0;
    end
  end

  // tokens from the byte itself, in order
  always_comb begin
    a0_v = fail_v | do_fin | (do_start & st_tok_v);
    a1_v = do_fin & do_start & st_tok_v;
    if (fail_v) begin
      a0 = mk_tok(KIND_ERROR, minus_r, start_r, fail_len, fail_cause);
    end else if (do_fin) begin
      a0 = fin_tok;
    end else begin
      a0 = st_tok;
    end
    a1 = st_tok;
  end

  // close whatever is pending at the end of the text
  always_comb begin
    b_v   = 1'b0;
    b_tok = finish_tok(m_mode, m_word, m_start, m_cnt, m_minus, m_point);
    if (eot_r) begin
      unique case (m_mode)
        M_ZERO: begin
          b_v   = 1'b1;
          b_tok = mk_tok(KIND_ERROR, m_minus, m_start, m_cnt, CAUSE_ZERO);
        end
        M_POINT, M_ZPOINT: begin
          b_v   = 1'b1;
          b_tok = mk_tok(KIND_ERROR, m_minus, m_start, m_cnt, CAUSE_TRAIL_PT);
        end
        M_WORD, M_MINUS, M_NUM: begin
          b_v = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // pack up to two tokens, mark the last one
  always_comb begin
    push.t0 = a0;
    push.t1 = a1;
    push.n  = 2'd0;
    if (a0_v && a1_v) begin
      push.n = 2'd2;
    end else if (a0_v) begin
      push.t1 = b_tok;
      push.n  = b_v ? 2'd2 : 2'd1;
    end else begin
      push.t0 = b_tok;
      push.n  = b_v ? 2'd1 : 2'd0;
    end
    if (!fire) push.n = 2'd0;
    push.t0.last = (push.n == 2'd1);
    push.t1.last = (push.n == 2'd2);
  end

  // next state; the end of the text returns everything to reset
  always_comb begin
    if (eot_r) begin
      mode_nxt  = M_IDLE;
      word_nxt  = 64'd0;
      start_nxt = '0;
      cnt_nxt   = '0;
      minus_nxt = 1'b0;
      point_nxt = 1'b0;
      pos_nxt   = '0;
    end else begin
      mode_nxt  = m_mode;
      word_nxt  = m_word;
      start_nxt = m_start;
      cnt_nxt   = m_cnt;
      minus_nxt = m_minus;
      point_nxt = m_point;
      pos_nxt   = POS_W'(pos_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      word_r  <= 64'd0;
      start_r <= '0;
      cnt_r   <= '0;
      minus_r <= 1'b0;
      point_r <= 1'b0;
      pos_r   <= '0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      word_r  <= word_nxt;
      start_r <= start_nxt;
      cnt_r   <= cnt_nxt;
      minus_r <= minus_nxt;
      point_r <= point_nxt;
      pos_r   <= pos_nxt;
    end
  end

`ifndef SYNTHESIS
  a_eot_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && eot_r) |=> (pos_r == '0) && (mode_r == M_IDLE))
    else $error("state not cleared after end of text");
  a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && mode_r == M_SKIP) |-> (push.n == 2'd0))
    else $error("token emitted while skipping");
  a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n == 2'd2) |-> (push.t1.last && !push.t0.last))
    else $error("run end on wrong token");
`endif

endmodule

/* sv/clex_outq.sv */
module clex_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  clex_pkg::push_t push,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output clex_pkg::tok_t  out_tok
);
  import clex_pkg::*;

  tok_t              q_r   [QDEPTH];
  tok_t              q_nxt [QDEPTH];
  logic [QCNT_W-1:0] cnt_r, cnt_nxt, cnt_p;
  logic              pop;

  assign out_valid = (cnt_r != '0);
  assign out_tok   = q_r[0];
  assign pop       = out_valid & out_ready;
  // leave space for two tokens from the next byte
  assign room      = (cnt_r <= QCNT_W'(QDEPTH - 2));

  always_comb begin
    cnt_p = QCNT_W'(cnt_r - QCNT_W'(pop));
    for (int i = 0; i < QDEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    for (int i = 0; i < QDEPTH - 1; i++) begin
      if (pop) q_nxt[i] = q_r[i + 1];
    end
    for (int i = 0; i < QDEPTH; i++) begin
      if ((push.n != 2'd0) && (cnt_p == QCNT_W'(i))) q_nxt[i] = push.t0;
      if ((push.n == 2'd2) && (QCNT_W'(cnt_p + 1'b1) == QCNT_W'(i))) q_nxt[i] = push.t1;
    end
    cnt_nxt = QCNT_W'(cnt_p + QCNT_W'(push.n));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && cnt_r == QCNT_W'(1) && push.n == 2'd0) |=> !out_valid)
    else $error("result queue not empty after last pop");
`endif

endmodule
